>>> sv/rbno_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Row block offset generator: shared package
// Widths, reset values and the request that travels from the front end to
// the result stage.
// ----------------------------------------------------------------------------
package rbno_pkg;

    // Fixed field widths of the result, row and configuration channels.
    localparam int OUT_W = 32;
    localparam int NZ_W  = 20;
    localparam int CFG_W = 11;

    // Reset value of the rows-per-block register.
    localparam logic [CFG_W-1:0] CFG_RESET = 11'd32;

    // Defaults of the top-level parameters.
    localparam int DEF_OFFSET_WIDTH   = 32;
    localparam int DEF_MAX_BLOCK_ROWS = 1024;

    // Depth of the queue between front end and result stage.
    localparam int QUEUE_DEPTH = 4;

    // One classified row: up to two offsets, each with its overflow flag.
    typedef struct packed {
        logic [OUT_W-1:0] first_val;
        logic             first_ovf;
        logic             second_vld;
        logic [OUT_W-1:0] second_val;
        logic             second_ovf;
    } t_cmd;

endpackage

>>> sv/rbno_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Row block offset generator: front end
// Holds the running offset and row count, classifies each accepted row and
// hands the offsets it causes to the queue as one request.
// ----------------------------------------------------------------------------
module rbno_front #(
    parameter int OFFSET_WIDTH   = rbno_pkg::DEF_OFFSET_WIDTH,
    parameter int MAX_BLOCK_ROWS = rbno_pkg::DEF_MAX_BLOCK_ROWS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_wr_en,
    input  logic [rbno_pkg::CFG_W-1:0] i_cfg_wr_data,
    input  logic                       i_accept,
    input  logic [rbno_pkg::NZ_W-1:0]  i_row_nonzeros,
    input  logic                       i_group_start,
    input  logic                       i_final_row,
    output logic                       o_cmd_push,
    output rbno_pkg::t_cmd             o_cmd
);
    import rbno_pkg::*;

    localparam int CNT_W = $clog2(MAX_BLOCK_ROWS + 1);
    localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam int SUM_W = ((OFFSET_WIDTH > NZ_W) ? OFFSET_WIDTH : NZ_W) + 1;
    localparam int EXT_W = (OFFSET_WIDTH > OUT_W) ? OFFSET_WIDTH : OUT_W;
    localparam logic [OFFSET_WIDTH-1:0] LIMIT    = '1;
    localparam logic [CMP_W-1:0]        MAX_ROWS = CMP_W'(MAX_BLOCK_ROWS);

    logic [CFG_W-1:0]        r_rows_per_block;
    logic [OFFSET_WIDTH-1:0] r_offset, n_offset;
    logic [CNT_W-1:0]        r_rows, n_rows;
    logic                    r_started, n_started;
    logic                    r_ovf, n_ovf;

    logic [CMP_W-1:0]        cfg_ext;
    logic [CMP_W-1:0]        eff_rows;
    logic                    emit_lead;
    logic                    emit_flush;
    logic                    emit_close;
    logic [CNT_W-1:0]        rows_a;
    logic [CNT_W-1:0]        rows_b;
    logic [SUM_W-1:0]        sum;
    logic                    sat;
    logic [OFFSET_WIDTH-1:0] offset_new;
    logic                    ovf_new;
    logic [EXT_W-1:0]        cur_ext;
    logic [EXT_W-1:0]        new_ext;

    // Effective block length: zero counts as one, large values are clamped.
    always_comb begin
        cfg_ext = CMP_W'(r_rows_per_block);
        if (cfg_ext == '0) begin
            eff_rows = CMP_W'(1);
        end else if (cfg_ext > MAX_ROWS) begin
            eff_rows = MAX_ROWS;
        end else begin
            eff_rows = cfg_ext;
        end
    end

    // Classify the row and work out the saturating running offset.
    always_comb begin
        emit_lead  = !r_started;
        emit_flush = i_group_start && (r_rows != '0);
        rows_a     = emit_flush ? '0 : r_rows;
        rows_b     = rows_a + CNT_W'(1);
        sum        = SUM_W'(r_offset) + SUM_W'(i_row_nonzeros);
        sat        = sum > SUM_W'(LIMIT);
        offset_new = sat ? LIMIT : sum[OFFSET_WIDTH-1:0];
        ovf_new    = r_ovf | sat;
        emit_close = (CMP_W'(rows_b) >= eff_rows) || i_final_row;
        cur_ext    = EXT_W'(r_offset);
        new_ext    = EXT_W'(offset_new);
    end

    // Build the request for the queue.
    always_comb begin
        o_cmd_push       = i_accept && (emit_lead || emit_flush || emit_close);
        o_cmd.second_vld = (emit_lead || emit_flush) && emit_close;
        o_cmd.second_val = new_ext[OUT_W-1:0];
        o_cmd.second_ovf = ovf_new;
        if (emit_lead) begin
            o_cmd.first_val = '0;
            o_cmd.first_ovf = r_ovf;
        end else if (emit_flush) begin
            o_cmd.first_val = cur_ext[OUT_W-1:0];
            o_cmd.first_ovf = r_ovf;
        end else begin
            o_cmd.first_val = new_ext[OUT_W-1:0];
            o_cmd.first_ovf = ovf_new;
        end
    end

    // Next state; the last row of a matrix clears offset, row count and flags.
    always_comb begin
        n_offset  = r_offset;
        n_rows    = r_rows;
        n_started = r_started;
        n_ovf     = r_ovf;
        if (i_accept) begin
            if (i_final_row) begin
                n_offset  = '0;
                n_rows    = '0;
                n_started = 1'b0;
                n_ovf     = 1'b0;
            end else begin
                n_offset  = offset_new;
                n_rows    = emit_close ? '0 : rows_b;
                n_started = 1'b1;
                n_ovf     = ovf_new;
            end
        end
    end

    // State and configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_per_block <= CFG_RESET;
            r_offset         <= '0;
            r_rows           <= '0;
            r_started        <= 1'b0;
            r_ovf            <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_rows_per_block <= i_cfg_wr_data;
            end
            r_offset  <= n_offset;
            r_rows    <= n_rows;
            r_started <= n_started;
            r_ovf     <= n_ovf;
        end
    end

endmodule

>>> sv/rbno_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Row block offset generator: request queue
// A short first-in first-out store that lets the front end run ahead of the
// result stage.
// ----------------------------------------------------------------------------
module rbno_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  rbno_pkg::t_cmd i_cmd,
    input  logic           i_pop,
    output rbno_pkg::t_cmd o_cmd,
    output logic           o_valid,
    output logic           o_full
);
    import rbno_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

    t_cmd             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    assign o_cmd   = r_mem[r_rd_ptr];
    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));

    // Pointer and fill level updates.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    // Storage write.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

>>> sv/rbno_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Row block offset generator: result stage
// Unpacks each queued request into one or two results and holds the oldest
// result in an output register until it is taken.
// ----------------------------------------------------------------------------
module rbno_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  rbno_pkg::t_cmd             i_cmd,
    input  logic                       i_cmd_vld,
    output logic                       o_cmd_deq,
    input  logic                       i_pop,
    output logic                       o_empty,
    output logic [rbno_pkg::OUT_W-1:0] o_block_begin,
    output logic                       o_run_last,
    output logic                       o_overflow
);
    import rbno_pkg::*;

    logic             r_phase, n_phase;
    logic             r_out_vld, n_out_vld;
    logic [OUT_W-1:0] r_val;
    logic             r_last;
    logic             r_ovf;

    logic             load;
    logic             sel_second;
    logic             is_last;

    // Pick the pending offset of the head request.
    always_comb begin
        load       = i_cmd_vld && (!r_out_vld || i_pop);
        sel_second = r_phase;
        is_last    = r_phase || !i_cmd.second_vld;
        o_cmd_deq  = load && is_last;
    end

    // Next phase and output valid.
    always_comb begin
        n_phase   = r_phase;
        n_out_vld = r_out_vld;
        if (load) begin
            n_phase   = !is_last;
            n_out_vld = 1'b1;
        end else if (i_pop) begin
            n_out_vld = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_phase   <= n_phase;
            r_out_vld <= n_out_vld;
        end
    end

    // Output payload register.
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_val  <= sel_second ? i_cmd.second_val : i_cmd.first_val;
            r_ovf  <= sel_second ? i_cmd.second_ovf : i_cmd.first_ovf;
            r_last <= is_last;
        end
    end

    assign o_empty       = !r_out_vld;
    assign o_block_begin = r_val;
    assign o_run_last    = r_last;
    assign o_overflow    = r_ovf;

endmodule

>>> sv/row_block_nonzero_offsets_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Row block offset generator: top level
// Turns a stream of per-row nonzero counts into the starting nonzero offset
// of every fixed-size row block, with saturation and a sticky overflow flag.
// ----------------------------------------------------------------------------
// Usage:
// Rows enter through push/full; a row is taken at a clock edge with push high
// and full low. Results leave through empty/pop; the oldest result sits on the
// result ports while empty is low and is taken on an edge with pop high.
// A row causes zero, one or two results; run_last marks the last of them.
// The front end takes one row per cycle while the four-entry request queue
// has room. The result stage gives one result per cycle while pop is high; a
// row causing two results holds the queue head until its second is loaded.
// A request is registered in the queue, then in the result register.
// When the receiver stalls, the result register holds and the queue fills;
// full rises once four requests are waiting, and rows that cause no result
// never occupy the queue.
// Reset (synchronous, active low) clears offsets, counters and the queue and
// sets rows_per_block to 32. Write rows_per_block only while idle.
// ----------------------------------------------------------------------------
module row_block_nonzero_offsets_top #(
    parameter int OFFSET_WIDTH   = rbno_pkg::DEF_OFFSET_WIDTH,
    parameter int MAX_BLOCK_ROWS = rbno_pkg::DEF_MAX_BLOCK_ROWS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_wr_en,
    input  logic [rbno_pkg::CFG_W-1:0] i_cfg_wr_data,
    input  logic                       push,
    output logic                       full,
    input  logic [rbno_pkg::NZ_W-1:0]  i_row_nonzeros,
    input  logic                       i_group_start,
    input  logic                       i_final_row,
    output logic                       empty,
    input  logic                       pop,
    output logic [rbno_pkg::OUT_W-1:0] o_block_begin,
    output logic                       o_run_last,
    output logic                       o_overflow
);
    import rbno_pkg::*;

    logic accept;
    logic cmd_push;
    t_cmd front_cmd;
    t_cmd head_cmd;
    logic head_vld;
    logic head_deq;
    logic q_full;

    assign full   = q_full;
    assign accept = push && !q_full;

    // Front end: state and classification.
    rbno_front #(
        .OFFSET_WIDTH   (OFFSET_WIDTH),
        .MAX_BLOCK_ROWS (MAX_BLOCK_ROWS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_accept       (accept),
        .i_row_nonzeros (i_row_nonzeros),
        .i_group_start  (i_group_start),
        .i_final_row    (i_final_row),
        .o_cmd_push     (cmd_push),
        .o_cmd          (front_cmd)
    );

    // Request queue between the two halves.
    rbno_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_cmd   (front_cmd),
        .i_pop   (head_deq),
        .o_cmd   (head_cmd),
        .o_valid (head_vld),
        .o_full  (q_full)
    );

    // Result stage.
    rbno_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (head_cmd),
        .i_cmd_vld     (head_vld),
        .o_cmd_deq     (head_deq),
        .i_pop         (pop),
        .o_empty       (empty),
        .o_block_begin (o_block_begin),
        .o_run_last    (o_run_last),
        .o_overflow    (o_overflow)
    );

endmodule

>>> sv/rbno_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Row block offset generator: port checker
// Watches the top-level ports for reset behaviour, stall behaviour and the
// saturated offset that must accompany the overflow flag.
// ----------------------------------------------------------------------------
module rbno_checker #(
    parameter int OFFSET_WIDTH = rbno_pkg::DEF_OFFSET_WIDTH
) (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       push,
    input logic                       full,
    input logic                       empty,
    input logic                       pop,
    input logic [rbno_pkg::OUT_W-1:0] o_block_begin,
    input logic                       o_run_last,
    input logic                       o_overflow
);
    import rbno_pkg::*;

    localparam logic [OUT_W-1:0] SAT_VAL = (OFFSET_WIDTH >= OUT_W) ? '1 :
        OUT_W'((65'(1) << OFFSET_WIDTH) - 65'(1));

    // After reset nothing is waiting and rows are accepted.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("queue not cleared by reset");

    // A stalled result keeps its value.
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_block_begin)
            && $stable(o_run_last) && $stable(o_overflow)))
        else $error("stalled result changed");

    // Once saturated, every offset reported is the saturation value.
    a_overflow_saturated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_overflow) |-> (o_block_begin == SAT_VAL))
        else $error("overflow flagged on unsaturated offset");

    // The queue can only fill through accepted rows.
    a_full_needs_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!full && !push) |=> !full)
        else $error("full rose without a request");

endmodule

bind row_block_nonzero_offsets_top rbno_checker #(
    .OFFSET_WIDTH (OFFSET_WIDTH)
) u_rbno_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .push          (push),
    .full          (full),
    .empty         (empty),
    .pop           (pop),
    .o_block_begin (o_block_begin),
    .o_run_last    (o_run_last),
    .o_overflow    (o_overflow)
);

>>> sim/row_block_nonzero_offsets_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Row block offset generator: self-checking testbench
// A directed table of rows and register writes comes first. Random matrices
// under several block sizes follow.
// Every accepted row request is run through a local offset tracker, and each
// result popped from the block is compared with the oldest expected offset.
// Both the row side and the result side idle and stall at random.
// ----------------------------------------------------------------------------
module row_block_nonzero_offsets_top_tb;
    import rbno_pkg::*;

    localparam int OFS_W       = DEF_OFFSET_WIDTH;
    localparam int BLK_MAX     = DEF_MAX_BLOCK_ROWS;
    localparam int SETTLE      = 6;
    localparam int DRAIN       = 10;
    localparam int IDLE_LIMIT  = 2000;
    localparam int PHASE_ROWS  = 25;
    localparam logic [NZ_W-1:0] NZ_MAX = '1;

    typedef enum logic {STEP_ROW, STEP_CFG} t_step_kind;

    // One line of the directed plan: a row request or a register write.
    typedef struct {
        t_step_kind       kind;
        logic [CFG_W-1:0] cfg;
        logic [NZ_W-1:0]  nz;
        logic             gs;
        logic             fin;
        logic             typed;
        int               n;
        logic [OUT_W-1:0] e0;
        logic [OUT_W-1:0] e1;
    } t_step;

    typedef struct packed {
        logic [OUT_W-1:0] ofs;
        logic             last;
        logic             ovf;
    } t_offset_rec;

    logic             i_clk         = 1'b0;
    logic             i_rst_n       = 1'b0;
    logic             i_cfg_wr_en   = 1'b0;
    logic [CFG_W-1:0] i_cfg_wr_data = '0;
    logic             push          = 1'b0;
    logic             full;
    logic [NZ_W-1:0]  i_row_nonzeros = '0;
    logic             i_group_start = 1'b0;
    logic             i_final_row   = 1'b0;
    logic             empty;
    logic             pop           = 1'b0;
    logic [OUT_W-1:0] o_block_begin;
    logic             o_run_last;
    logic             o_overflow;

    // Typed expectation that travels with the row request being offered.
    logic             drv_typed = 1'b0;
    int               drv_exp_n = 0;
    logic [OUT_W-1:0] drv_exp0  = '0;
    logic [OUT_W-1:0] drv_exp1  = '0;

    // Offset tracker state and the results of the latest row.
    logic [CFG_W-1:0] blk_cfg;
    logic [OFS_W-1:0] nz_total;
    logic [CFG_W-1:0] rows_open;
    logic             lead_sent;
    logic             sat_seen;
    t_offset_rec      row_offsets [0:2];
    int               row_offsets_n;

    t_offset_rec      pend_q [$];
    int               err_cnt    = 0;
    int               idle_count = 0;
    bit               calm_in    = 1'b0;

    // Directed plan: reset state, extremes, group starts on full and empty
    // row blocks, register zero, register above the maximum, small blocks.
    t_step plan [0:23] = '{
        '{STEP_ROW, 11'd0,    20'h00000, 1'b1, 1'b0, 1'b1, 1, 32'd0,       32'd0},
        '{STEP_ROW, 11'd0,    20'hFFFFF, 1'b0, 1'b1, 1'b1, 1, 32'h000FFFFF, 32'd0},
        '{STEP_ROW, 11'd0,    20'h00005, 1'b0, 1'b1, 1'b1, 2, 32'd0,       32'd5},
        '{STEP_ROW, 11'd0,    20'h00007, 1'b1, 1'b0, 1'b1, 1, 32'd0,       32'd0},
        '{STEP_ROW, 11'd0,    20'h00003, 1'b1, 1'b0, 1'b1, 1, 32'd7,       32'd0},
        '{STEP_ROW, 11'd0,    20'h00001, 1'b1, 1'b1, 1'b1, 2, 32'd10,      32'd11},
        '{STEP_CFG, 11'd0,    20'h00000, 1'b0, 1'b0, 1'b0, 0, 32'd0,       32'd0},
        '{STEP_ROW, 11'd0,    20'h00004, 1'b0, 1'b0, 1'b1, 2, 32'd0,       32'd4},
        '{STEP_ROW, 11'd0,    20'h00006, 1'b1, 1'b0, 1'b1, 1, 32'd10,      32'd0},
        '{STEP_ROW, 11'd0,    20'h00000, 1'b0, 1'b1, 1'b1, 1, 32'd10,      32'd0},
        '{STEP_CFG, 11'd2047, 20'h00000, 1'b0, 1'b0, 1'b0, 0, 32'd0,       32'd0},
        '{STEP_ROW, 11'd0,    20'h00001, 1'b1, 1'b0, 1'b1, 1, 32'd0,       32'd0},
        '{STEP_ROW, 11'd0,    20'h00002, 1'b0, 1'b0, 1'b1, 0, 32'd0,       32'd0},
        '{STEP_ROW, 11'd0,    20'h00003, 1'b1, 1'b0, 1'b1, 1, 32'd3,       32'd0},
        '{STEP_ROW, 11'd0,    20'hFFFFF, 1'b0, 1'b0, 1'b0, 0, 32'd0,       32'd0},
        '{STEP_ROW, 11'd0,    20'h00009, 1'b0, 1'b1, 1'b0, 0, 32'd0,       32'd0},
        '{STEP_CFG, 11'd2,    20'h00000, 1'b0, 1'b0, 1'b0, 0, 32'd0,       32'd0},
        '{STEP_ROW, 11'd0,    20'h00001, 1'b0, 1'b0, 1'b1, 1, 32'd0,       32'd0},
        '{STEP_ROW, 11'd0,    20'h00001, 1'b0, 1'b0, 1'b1, 1, 32'd2,       32'd0},
        '{STEP_ROW, 11'd0,    20'h00001, 1'b1, 1'b0, 1'b1, 0, 32'd0,       32'd0},
        '{STEP_ROW, 11'd0,    20'h00001, 1'b0, 1'b1, 1'b1, 1, 32'd4,       32'd0},
        '{STEP_ROW, 11'd0,    20'h00000, 1'b1, 1'b1, 1'b1, 2, 32'd0,       32'd0},
        '{STEP_ROW, 11'd0,    20'hFFFFF, 1'b1, 1'b0, 1'b0, 0, 32'd0,       32'd0},
        '{STEP_ROW, 11'd0,    20'hABCDE, 1'b0, 1'b1, 1'b0, 0, 32'd0,       32'd0}
    };

    row_block_nonzero_offsets_top i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .push           (push),
        .full           (full),
        .i_row_nonzeros (i_row_nonzeros),
        .i_group_start  (i_group_start),
        .i_final_row    (i_final_row),
        .empty          (empty),
        .pop            (pop),
        .o_block_begin  (o_block_begin),
        .o_run_last     (o_run_last),
        .o_overflow     (o_overflow)
    );

    // 12 ns clock.
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input logic [OUT_W-1:0] got,
                                   input logic [OUT_W-1:0] want);
        if (err_cnt < 50)
            $display("MISMATCH %s: got %0h, want %0h at %0t", what, got, want, $time);
        err_cnt++;
    endtask

    // Block size in force: zero counts as one, large values are clipped.
    function automatic logic [CFG_W-1:0] block_size();
        if (blk_cfg == '0)
            return CFG_W'(1);
        if (blk_cfg > CFG_W'(BLK_MAX))
            return CFG_W'(BLK_MAX);
        return blk_cfg;
    endfunction

    task automatic clear_tracker();
        nz_total  = '0;
        rows_open = '0;
        lead_sent = 1'b0;
        sat_seen  = 1'b0;
    endtask

    task automatic add_offset(input logic [OFS_W-1:0] value);
        row_offsets[row_offsets_n] = '{OUT_W'(value), 1'b0, sat_seen};
        row_offsets_n++;
    endtask

    // Appends one expected result behind those already waiting.
    task automatic queue_expected(input t_offset_rec rec);
        pend_q.insert(pend_q.size(), rec);
    endtask

    // Works out the offsets that one accepted row causes.
    task automatic advance_offsets(input logic [NZ_W-1:0] nz, input logic gs,
                                   input logic fin);
        logic [OFS_W:0] sum;
        row_offsets_n = 0;
        if (!lead_sent) begin
            nz_total  = '0;
            rows_open = '0;
            lead_sent = 1'b1;
            add_offset('0);
        end
        // A new thread block closes a row block that already holds rows.
        if (gs && rows_open != '0) begin
            add_offset(nz_total);
            rows_open = '0;
        end
        sum = {1'b0, nz_total} + (OFS_W + 1)'(nz);
        if (sum[OFS_W]) begin
            nz_total = '1;
            sat_seen = 1'b1;
        end else begin
            nz_total = sum[OFS_W-1:0];
        end
        rows_open++;
        if (rows_open >= block_size() || fin) begin
            add_offset(nz_total);
            rows_open = '0;
        end
        if (row_offsets_n > 0)
            row_offsets[row_offsets_n-1].last = 1'b1;
        // The last row ends the matrix and the next row starts afresh.
        if (fin)
            clear_tracker();
    endtask

    // Tracks requests on both sides, checks results and watches for a hang.
    always @(posedge i_clk) begin : offset_scoreboard
        t_offset_rec got_rec;
        t_offset_rec want_rec;
        logic        moved;
        int          k;
        moved = 1'b0;
        if (!i_rst_n) begin
            clear_tracker();
            blk_cfg = CFG_RESET;
            pend_q.delete();
        end else begin
            if (i_cfg_wr_en)
                blk_cfg = i_cfg_wr_data;
            if (push && !full) begin
                moved = 1'b1;
                advance_offsets(i_row_nonzeros, i_group_start, i_final_row);
                if (drv_typed) begin
                    for (k = 0; k < drv_exp_n; k++) begin
                        want_rec.ofs  = (k == 0) ? drv_exp0 : drv_exp1;
                        want_rec.last = (k == drv_exp_n - 1);
                        want_rec.ovf  = 1'b0;
                        queue_expected(want_rec);
                    end
                end else begin
                    for (k = 0; k < row_offsets_n; k++)
                        queue_expected(row_offsets[k]);
                end
            end
            if (pop && !empty) begin
                moved = 1'b1;
                got_rec = '{o_block_begin, o_run_last, o_overflow};
                if (pend_q.size() == 0) begin
                    report_mismatch("result with none expected", got_rec.ofs, '0);
                end else begin
                    want_rec = pend_q.pop_front();
                    if (got_rec.ofs != want_rec.ofs)
                        report_mismatch("block_begin", got_rec.ofs, want_rec.ofs);
                    if (got_rec.last != want_rec.last)
                        report_mismatch("run_last", OUT_W'(got_rec.last),
                                        OUT_W'(want_rec.last));
                    if (got_rec.ovf != want_rec.ovf)
                        report_mismatch("overflow", OUT_W'(got_rec.ovf),
                                        OUT_W'(want_rec.ovf));
                end
            end
        end
        // Watchdog: too long without any request moving means a hang.
        idle_count = moved ? 0 : idle_count + 1;
        if (idle_count >= IDLE_LIMIT) begin
            $display("row_block_nonzero_offsets_top verification failed");
            $finish;
        end
    end

    // Mostly short gaps, a few long ones, none at all in a calm stretch.
    function automatic int unsigned pick_gap(input bit calm);
        int unsigned r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    function automatic logic [NZ_W-1:0] pick_nz();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        if (r == 1)
            return NZ_MAX;
        return NZ_W'($urandom());
    endfunction

    // Offers one row request and holds it until the block takes it.
    task automatic send_row(input t_step s);
        int unsigned gap;
        gap = pick_gap(calm_in);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push           <= 1'b1;
        i_row_nonzeros <= s.nz;
        i_group_start  <= s.gs;
        i_final_row    <= s.fin;
        drv_typed      <= s.typed;
        drv_exp_n      <= s.n;
        drv_exp0       <= s.e0;
        drv_exp1       <= s.e1;
        do
            @(posedge i_clk);
        while (full);
    endtask

    task automatic send_plain(input logic [NZ_W-1:0] nz, input logic gs, input logic fin);
        t_step s;
        s = '{STEP_ROW, '0, nz, gs, fin, 1'b0, 0, '0, '0};
        send_row(s);
    endtask

    // Waits until the block is idle, then writes the block size register.
    task automatic write_block_size(input logic [CFG_W-1:0] value);
        push <= 1'b0;
        @(posedge i_clk);
        while (pend_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
    endtask

    // Result side: stall runs of random length with calm stretches between.
    initial begin : result_sink
        int unsigned stall;
        int unsigned run;
        @(posedge i_clk);
        forever begin
            if ($urandom_range(0, 9) == 0) begin
                stall = 0;
                run   = $urandom_range(40, 200);
            end else begin
                stall = pick_gap(1'b0);
                run   = $urandom_range(1, 6);
            end
            if (stall > 0) begin
                pop <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            pop <= 1'b1;
            repeat (run) @(posedge i_clk);
        end
    end

    // Row side: reset, directed plan, then random matrices.
    initial begin : row_source
        logic [CFG_W-1:0] phase_cfg [0:7];
        int               rows_left;
        int               len;
        int               i;
        int               j;
        phase_cfg = '{CFG_W'(0), CFG_W'(1), CFG_W'(2047), CFG_W'(1024),
                      CFG_W'($urandom_range(2, 6)), CFG_W'($urandom()),
                      CFG_W'(32), CFG_W'($urandom_range(2, 6))};
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (i = 0; i < $size(plan); i++) begin
            if (plan[i].kind == STEP_CFG)
                write_block_size(plan[i].cfg);
            else
                send_row(plan[i]);
        end

        // Random matrices: mostly well formed, with some loose rows between.
        for (i = 0; i < $size(phase_cfg); i++) begin
            write_block_size(phase_cfg[i]);
            calm_in   = ($urandom_range(0, 3) == 0);
            rows_left = PHASE_ROWS;
            while (rows_left > 0) begin
                if ($urandom_range(0, 4) == 0) begin
                    send_plain(pick_nz(), 1'($urandom_range(0, 1)),
                               $urandom_range(0, 7) == 0);
                    rows_left--;
                end else begin
                    len = $urandom_range(1, 12);
                    if (len > rows_left)
                        len = rows_left;
                    for (j = 0; j < len; j++)
                        send_plain(pick_nz(),
                                   (j == 0) ? ($urandom_range(0, 4) != 0)
                                            : ($urandom_range(0, 5) == 0),
                                   j == len - 1);
                    rows_left -= len;
                end
            end
        end

        // Let every outstanding result drain, then idle for the DRAIN margin.
        push <= 1'b0;
        @(posedge i_clk);
        while (pend_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
        if (err_cnt == 0 && pend_q.size() == 0)
            $display("row_block_nonzero_offsets_top verification clean");
        else
            $display("row_block_nonzero_offsets_top verification failed");
        $finish;
    end

endmodule
